// File: hdl/dbrb_pkg.sv
package dbrb_pkg;

    localparam int DEF_BLOCK_BYTES = 64;
    localparam int DEF_CHANNELS    = 4;
    localparam int DEF_ROWS        = 1024;

    localparam int IN_W  = 296;
    localparam int OUT_W = 264;

    localparam logic [2:0] OP_ACTIVATE = 3'd1;
    localparam logic [2:0] OP_COLUMN   = 3'd2;
    localparam logic [2:0] OP_OUTPUT   = 3'd3;
    localparam logic [2:0] OP_WRITE    = 3'd4;
    localparam logic [2:0] OP_DONE     = 3'd5;

    localparam logic [4:0] NO_OFFSET = 5'd16;

    typedef struct packed {
        logic clear;
        logic take;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_last;
    } t_dp_sts;

endpackage

// File: hdl/dbrb_ram.sv
module dbrb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: hdl/dbrb_ctrl.sv
module dbrb_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    input  dbrb_pkg::t_dp_sts i_sts,
    output dbrb_pkg::t_dp_cmd o_cmd
);
    import dbrb_pkg::*;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_RESP
    } t_state;

    t_state r_state, n_state;
    logic   r_ovalid, n_ovalid;
    logic   ready;

    always_comb begin
        n_state  = r_state;
        o_cmd    = '0;
        ready    = 1'b0;
        n_ovalid = r_ovalid && !i_m_tready;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                ready = !r_ovalid || i_m_tready;
                if (i_s_tvalid && ready) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_RESP;
                end
            end
            S_RESP: begin
                o_cmd.finish = 1'b1;
                n_ovalid     = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_s_tready = ready;
    assign o_m_tvalid = r_ovalid;
endmodule

// File: hdl/dbrb_dp.sv
module dbrb_dp #(
    parameter int BLOCK_BYTES = dbrb_pkg::DEF_BLOCK_BYTES,
    parameter int CHANNELS    = dbrb_pkg::DEF_CHANNELS,
    parameter int ROWS        = dbrb_pkg::DEF_ROWS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  dbrb_pkg::t_dp_cmd           i_cmd,
    output dbrb_pkg::t_dp_sts           o_sts,
    input  logic [dbrb_pkg::IN_W-1:0]   i_in,
    input  logic                        i_cfg_we,
    input  logic [3:0]                  i_cfg_data,
    output logic [3:0]                  o_own,
    output logic [dbrb_pkg::OUT_W-1:0]  o_out
);
    import dbrb_pkg::*;

    localparam int WORDS    = BLOCK_BYTES / 8;
    localparam int CHUNKS   = BLOCK_BYTES / 16;
    localparam int KW       = $clog2(CHUNKS);
    localparam int WIW      = KW + 1;
    localparam int ROW_W    = $clog2(ROWS);
    localparam int ROW_BITS = WORDS * 64;

    logic        in_valid, in_wready;
    logic [3:0]  in_bank, in_offset;
    logic [2:0]  in_chan, in_op;
    logic [19:0] in_addr;
    logic [63:0] in_w [4];

    logic [3:0]  r_own;
    logic [2:0]  r_chan;
    logic        r_held, r_freed, r_rv, r_act;
    logic [19:0] r_addr;
    logic [4:0]  r_last;
    logic [63:0] r_fetch [WORDS];
    logic [63:0] r_row   [WORDS];
    logic [63:0] r_rd    [4];
    logic [ROW_W-1:0] r_clr_addr;
    logic [OUT_W-1:0] r_out;

    logic             hit, eff_held, wr_take, n_rv;
    logic [19:0]      eff_addr;
    logic [ROW_W-1:0] row;
    logic [KW-1:0]    k, k2;
    logic [WIW-1:0]   wi0, wi1, wi2, wi3;
    logic [63:0]      merged [WORDS];
    logic [ROW_BITS-1:0] merged_flat, mem_q;
    logic             wr_q;

    assign in_valid  = i_in[0];
    assign in_bank   = i_in[4:1];
    assign in_chan   = i_in[7:5];
    assign in_addr   = i_in[27:8];
    assign in_op     = i_in[30:28];
    assign in_offset = i_in[34:31];
    assign in_wready = i_in[35];
    assign in_w[0]   = i_in[99:36];
    assign in_w[1]   = i_in[163:100];
    assign in_w[2]   = i_in[227:164];
    assign in_w[3]   = i_in[291:228];

    always_comb begin
        hit      = in_valid && (in_bank == r_own) && (in_chan < 3'(CHANNELS));
        eff_held = hit || r_held;
        eff_addr = hit ? in_addr : r_addr;
        row      = ROW_W'((eff_addr >> KW) % ROWS);
        k        = (CHUNKS <= 2) ? '0 : in_offset[KW-1:0];
        k2       = k + 1'b1;
        wi0      = {k, 1'b0};
        wi1      = {k, 1'b1};
        wi2      = {k2, 1'b0};
        wi3      = {k2, 1'b1};
        wr_take  = eff_held && (in_op == OP_WRITE) && in_wready && (r_last != 5'(k));
        for (int i = 0; i < WORDS; i++) begin
            merged[i] = r_row[i];
        end
        merged[wi0] = in_w[0];
        merged[wi1] = in_w[1];
        merged[wi2] = in_w[2];
        merged[wi3] = in_w[3];
        for (int i = 0; i < WORDS; i++) begin
            merged_flat[i*64 +: 64] = merged[i];
        end
        n_rv = hit ? 1'b0 : r_rv;
        if (!eff_held) begin
            n_rv = 1'b0;
        end else begin
            case (in_op)
                OP_OUTPUT: n_rv = 1'b1;
                OP_WRITE:  n_rv = wr_take ? 1'b0 : n_rv;
                default:   n_rv = 1'b0;
            endcase
        end
    end

    dbrb_ram #(.WIDTH(ROW_BITS), .DEPTH(ROWS)) u_row_mem (
        .i_clk   (i_clk),
        .i_we    (i_cmd.take && wr_take),
        .i_waddr (row),
        .i_wdata (merged_flat),
        .i_raddr (row),
        .o_rdata (mem_q)
    );

    dbrb_ram #(.WIDTH(1), .DEPTH(ROWS)) u_written (
        .i_clk   (i_clk),
        .i_we    (i_cmd.clear || (i_cmd.take && wr_take)),
        .i_waddr (i_cmd.clear ? r_clr_addr : row),
        .i_wdata (!i_cmd.clear),
        .i_raddr (row),
        .o_rdata (wr_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own      <= '0;
            r_chan     <= '0;
            r_held     <= 1'b0;
            r_freed    <= 1'b0;
            r_rv       <= 1'b0;
            r_act      <= 1'b0;
            r_addr     <= '0;
            r_last     <= NO_OFFSET;
            r_clr_addr <= '0;
            for (int i = 0; i < WORDS; i++) begin
                r_fetch[i] <= '0;
                r_row[i]   <= '0;
            end
            for (int i = 0; i < 4; i++) begin
                r_rd[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_own <= i_cfg_data;
            end
            if (i_cmd.clear) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.take) begin
                if (hit) begin
                    r_chan <= in_chan;
                    r_addr <= in_addr;
                    r_held <= 1'b1;
                end
                r_rv  <= n_rv;
                r_act <= eff_held && (in_op == OP_ACTIVATE);
                if (eff_held) begin
                    case (in_op)
                        OP_COLUMN: begin
                            for (int i = 0; i < WORDS; i++) begin
                                r_row[i] <= r_fetch[i];
                            end
                        end
                        OP_OUTPUT: begin
                            r_rd[0] <= r_row[wi0];
                            r_rd[1] <= r_row[wi1];
                            r_rd[2] <= r_row[wi2];
                            r_rd[3] <= r_row[wi3];
                        end
                        OP_WRITE: begin
                            if (wr_take) begin
                                for (int i = 0; i < WORDS; i++) begin
                                    r_row[i] <= merged[i];
                                end
                                r_last <= 5'(k);
                            end
                        end
                        OP_DONE: begin
                            r_held  <= 1'b0;
                            r_last  <= NO_OFFSET;
                            r_freed <= 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            if (i_cmd.finish && r_act && wr_q) begin
                for (int i = 0; i < WORDS; i++) begin
                    r_fetch[i] <= mem_q[i*64 +: 64];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out <= {2'b00, r_freed, r_chan, r_held,
                      r_rd[3], r_rd[2], r_rd[1], r_rd[0], r_rv};
        end
    end

    assign o_sts.clear_last = (r_clr_addr == ROW_W'(ROWS - 1));
    assign o_own            = r_own;
    assign o_out            = r_out;
endmodule

// File: hdl/dram_bank_row_buffer_unit.sv
// Channel   Dir  Handshake              Payload
// s_axis    in   tvalid/tready          select, opcode, offset, write data
// m_axis    out  tvalid/tready          read data, busy, channel, freed
// apb       in   psel/penable/pready    own bank number at address 0
//
// For each request the command is applied first and the result is loaded after it.
// Activate reads the whole row in one memory access with a registered read.
// After reset a sweep clears every row of the row-written table, with s_axis_tready low.
// A stalled result holds the next request until it is taken.
module dram_bank_row_buffer_unit #(
    parameter int BLOCK_BYTES = dbrb_pkg::DEF_BLOCK_BYTES,
    parameter int CHANNELS    = dbrb_pkg::DEF_CHANNELS,
    parameter int ROWS        = dbrb_pkg::DEF_ROWS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // valid, bank[4], channel[3], addr[20], opcode[3], offset[4], wready, w0..w3[64]
    input  logic [dbrb_pkg::IN_W-1:0]  s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // read_valid, r0..r3[64], busy, channel[3], freed
    output logic [dbrb_pkg::OUT_W-1:0] m_axis_tdata,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic                       paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import dbrb_pkg::*;

    t_dp_cmd    cmd;
    t_dp_sts    sts;
    logic       cfg_we;
    logic [3:0] own;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && !paddr;
    assign prdata = paddr ? 32'd0 : {28'd0, own};

    dbrb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    dbrb_dp #(
        .BLOCK_BYTES (BLOCK_BYTES),
        .CHANNELS    (CHANNELS),
        .ROWS        (ROWS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_in       (s_axis_tdata),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (pwdata[3:0]),
        .o_own      (own),
        .o_out      (m_axis_tdata)
    );

    a_no_take_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.clear |-> !s_axis_tready) else $error("request taken during clear");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second request taken while busy");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> ##1 m_axis_tvalid)
        else $error("result missing after request");
endmodule
